FILE: hw/rtl/plic_pkg.sv
// Shared types and constants of the per-link interval load counter.
// Used by plic_ctrl, plic_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package plic_pkg;

	localparam int NUM_LINKS_DEF = 64;
	localparam int TIME_BITS_DEF = 48;

	localparam int ID_W      = 6;
	localparam int WORD_W    = 48;
	localparam int BYTE_W    = 16;
	localparam int QUEUE_W   = 32;
	localparam int CFG_IDX_W = 1;

	// link_index, now_ps, byte_count, queue_depth, padded to bytes
	localparam int IN_TDATA_W  = 104;
	// link_id, bucket_number, bucket_bytes, bucket_max_queue, padded to bytes
	localparam int OUT_TDATA_W = 136;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_PS   = 1'd1;

	localparam logic [WORD_W-1:0] INTERVAL_RST = 48'd1000000000;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_UPD,
		S_FL_RD,
		S_FL_EMIT
	} state_t;

	typedef struct packed {
		logic latch_in;        // capture the accepted item
		logic div_start;       // load the bucket divider
		logic sel_flush;       // table address from the flush scan counter
		logic rec_write;       // write back the updated record row
		logic flush_write;     // clear counters of the scanned link
		logic emit;            // load the output register
		logic scan_clr;
		logic scan_inc;
		logic set_flush_done;
	} cmd_t;

	typedef struct packed {
		logic op_flush;
		logic ignore;          // item has no effect
		logic div_done;
		logic row_valid;       // link at the table address has been seen
		logic row_nonempty;    // link holds bytes or a queue maximum
		logic bucket_diff;     // new bucket differs from the stored one
		logic out_free;
		logic scan_last;
	} stat_t;

endpackage

FILE: hw/rtl/plic_ctrl.sv
// Sequencer of the per-link interval load counter.
// Drives plic_datapath through plic_pkg::cmd_t, reads plic_pkg::stat_t.
`timescale 1ns / 1ps

module plic_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  plic_pkg::stat_t stat,
	output plic_pkg::cmd_t  cmd
);

	plic_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plic_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			plic_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = plic_pkg::S_CHECK;
				end
			end
			plic_pkg::S_CHECK: begin
				if (stat.ignore) begin
					state_d = plic_pkg::S_IDLE;
				end else if (stat.op_flush) begin
					cmd.scan_clr = 1'b1;
					state_d      = plic_pkg::S_FL_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = plic_pkg::S_DIV;
				end
			end
			plic_pkg::S_DIV: begin
				if (stat.div_done) begin
					state_d = plic_pkg::S_UPD;
				end
			end
			plic_pkg::S_UPD: begin
				// a finished nonempty bucket has to leave before the row is rewritten
				if (stat.row_valid && stat.bucket_diff && stat.row_nonempty) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.rec_write = 1'b1;
						state_d       = plic_pkg::S_IDLE;
					end
				end else begin
					cmd.rec_write = 1'b1;
					state_d       = plic_pkg::S_IDLE;
				end
			end
			plic_pkg::S_FL_RD: begin
				cmd.sel_flush = 1'b1;
				if (stat.row_nonempty) begin
					state_d = plic_pkg::S_FL_EMIT;
				end else if (stat.scan_last) begin
					cmd.set_flush_done = 1'b1;
					state_d            = plic_pkg::S_IDLE;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			plic_pkg::S_FL_EMIT: begin
				cmd.sel_flush = 1'b1;
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.flush_write = 1'b1;
					if (stat.scan_last) begin
						cmd.set_flush_done = 1'b1;
						state_d            = plic_pkg::S_IDLE;
					end else begin
						cmd.scan_inc = 1'b1;
						state_d      = plic_pkg::S_FL_RD;
					end
				end
			end
			default: begin
				state_d = plic_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/plic_datapath.sv
// Datapath: configuration registers, item registers, bit-serial bucket divider,
// link table memory with valid/nonempty flags, output register. Uses plic_pkg.
`timescale 1ns / 1ps

module plic_datapath #(
	parameter int NUM_LINKS = plic_pkg::NUM_LINKS_DEF,
	parameter int TIME_BITS = plic_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [plic_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plic_pkg::WORD_W-1:0]         cfg_data,
	input  logic                                in_tuser,
	input  logic [plic_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  plic_pkg::cmd_t                      cmd,
	output plic_pkg::stat_t                     stat,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [plic_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast
);

	localparam int WW     = plic_pkg::WORD_W;
	localparam int QW     = plic_pkg::QUEUE_W;
	localparam int BW     = plic_pkg::BYTE_W;
	localparam int IW     = plic_pkg::ID_W;
	localparam int DIV_W  = (TIME_BITS < WW) ? TIME_BITS : WW;
	localparam int LINK_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int NCNT_W = $clog2(NUM_LINKS + 1);

	typedef struct packed {
		logic [WW-1:0] bucket;
		logic [WW-1:0] bytes;
		logic [QW-1:0] max_queue;
	} row_t;

	// configuration
	logic          enable_q;
	logic [WW-1:0] interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			interval_q <= plic_pkg::INTERVAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				plic_pkg::REG_SAMPLE_ENABLE: enable_q   <= cfg_data[0];
				plic_pkg::REG_INTERVAL_PS:   interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item
	logic          item_op_q;
	logic [IW-1:0] item_idx_q;
	logic [WW-1:0] item_now_q;
	logic [BW-1:0] item_cnt_q;
	logic [QW-1:0] item_qd_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			item_op_q  <= in_tuser;
			item_idx_q <= in_tdata[IW-1:0];
			item_now_q <= in_tdata[IW+WW-1:IW];
			item_cnt_q <= in_tdata[IW+WW+BW-1:IW+WW];
			item_qd_q  <= in_tdata[IW+WW+BW+QW-1:IW+WW+BW];
		end
	end

	logic [DIV_W-1:0] ivl;
	logic             out_of_range;
	logic             rec_ignore;
	logic             flush_done_q;

	assign ivl          = interval_q[DIV_W-1:0];
	assign out_of_range = {1'b0, item_idx_q} >= (IW + 1)'(NUM_LINKS);
	assign rec_ignore   = !enable_q || (item_cnt_q == '0) || (ivl == '0) || out_of_range;

	// restoring divider, one quotient bit per cycle
	logic [DIV_W:0]    rem_q;
	logic [DIV_W-1:0]  quot_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIV_W:0]    rem_sh;

	assign rem_sh = {rem_q[DIV_W-1:0], quot_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= DCNT_W'(DIV_W);
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (dcnt_q != DCNT_W'(DIV_W)) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= '0;
			quot_q <= item_now_q[DIV_W-1:0];
		end else if (dcnt_q != DCNT_W'(DIV_W)) begin
			if (rem_sh >= {1'b0, ivl}) begin
				rem_q  <= rem_sh - {1'b0, ivl};
				quot_q <= {quot_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// link table
	row_t                 mem [NUM_LINKS];
	row_t                 rd_q;
	row_t                 wr_row;
	logic [LINK_W-1:0]    addr;
	logic [LINK_W-1:0]    scan_q;
	logic [NUM_LINKS-1:0] valid_q;
	logic [NUM_LINKS-1:0] nonempty_q;
	logic [NCNT_W-1:0]    ne_cnt_q;
	logic                 fresh;
	logic [WW:0]          byte_sum;
	logic [WW-1:0]        quot_ext;

	assign addr     = cmd.sel_flush ? scan_q : item_idx_q[LINK_W-1:0];
	assign quot_ext = WW'(quot_q);
	assign fresh    = !valid_q[addr] || (rd_q.bucket != quot_ext);
	assign byte_sum = {1'b0, rd_q.bytes} + (WW + 1)'(item_cnt_q);

	always_comb begin
		wr_row = rd_q;
		if (cmd.flush_write) begin
			wr_row.bytes     = '0;
			wr_row.max_queue = '0;
		end else begin
			wr_row.bucket = quot_ext;
			if (fresh) begin
				wr_row.bytes     = WW'(item_cnt_q);
				wr_row.max_queue = item_qd_q;
			end else begin
				wr_row.bytes     = byte_sum[WW] ? {WW{1'b1}} : byte_sum[WW-1:0];
				wr_row.max_queue = (item_qd_q > rd_q.max_queue) ? item_qd_q : rd_q.max_queue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_write || cmd.flush_write) begin
			mem[addr] <= wr_row;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			nonempty_q   <= '0;
			ne_cnt_q     <= '0;
			scan_q       <= '0;
			flush_done_q <= 1'b0;
		end else begin
			if (cmd.rec_write) begin
				valid_q[addr] <= 1'b1;
				// every counted record leaves the link nonempty
				if (!nonempty_q[addr]) begin
					nonempty_q[addr] <= 1'b1;
					ne_cnt_q         <= ne_cnt_q + 1'b1;
				end
			end
			if (cmd.flush_write) begin
				nonempty_q[addr] <= 1'b0;
				ne_cnt_q         <= ne_cnt_q - 1'b1;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.set_flush_done) begin
				flush_done_q <= 1'b1;
			end
		end
	end

	// output register
	logic          out_valid_q;
	logic [IW-1:0] out_id_q;
	row_t          out_row_q;
	logic          out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_id_q   <= IW'(addr);
			out_row_q  <= rd_q;
			// on a flush the last remaining nonempty link closes the run
			out_last_q <= cmd.sel_flush ? (ne_cnt_q == NCNT_W'(1)) : 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_row_q.max_queue, out_row_q.bytes,
		out_row_q.bucket, out_id_q};

	assign stat.op_flush     = (item_op_q == plic_pkg::OP_FLUSH);
	assign stat.ignore       = (item_op_q == plic_pkg::OP_FLUSH) ?
		(!enable_q || flush_done_q) : rec_ignore;
	assign stat.div_done     = (dcnt_q == DCNT_W'(DIV_W));
	assign stat.row_valid    = valid_q[addr];
	assign stat.row_nonempty = nonempty_q[addr];
	assign stat.bucket_diff  = (rd_q.bucket != quot_ext);
	assign stat.out_free     = !out_valid_q || m_axis_tready;
	assign stat.scan_last    = (scan_q == LINK_W'(NUM_LINKS - 1));

endmodule

FILE: hw/rtl/per_link_interval_load_counter_top.sv
// Record: accept, check, divide (DIV_W = min(TIME_BITS,48) quotient bits), then
// update, which waits on the output register when a finished bucket is reported.
// Flush: accept, check, then a scan over every link of the table, with an extra
// emit step for each reported link. One item is worked at a time.
// Reset (arst_n, async low) clears control, valid and nonempty flags at once;
// the table memory is not swept.
`timescale 1ns / 1ps

module per_link_interval_load_counter_top #(
	parameter int NUM_LINKS = plic_pkg::NUM_LINKS_DEF,
	parameter int TIME_BITS = plic_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [plic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plic_pkg::WORD_W-1:0]        cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// link_index[5:0], now_ps[53:6], byte_count[69:54], queue_depth[101:70], zeros
	input  logic [plic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// link_id[5:0], bucket_number[53:6], bucket_bytes[101:54],
	// bucket_max_queue[133:102], zeros
	output logic [plic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                               m_axis_tlast
);

	plic_pkg::cmd_t  cmd;
	plic_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	plic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plic_datapath #(
		.NUM_LINKS (NUM_LINKS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_tuser      (s_axis_tuser),
		.in_tdata      (s_axis_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: bench/per_link_interval_load_counter_top_tb.sv
// Self-checking bench for per_link_interval_load_counter_top: stream driver, result monitor,
// and a per-link bucket predictor that is checked against every reported bucket.
// Depends on plic_pkg and the top level only.
`timescale 1ns / 1ps

module per_link_interval_load_counter_top_tb;

	localparam int ID_W        = plic_pkg::ID_W;
	localparam int WORD_W      = plic_pkg::WORD_W;
	localparam int BYTE_W      = plic_pkg::BYTE_W;
	localparam int QUEUE_W     = plic_pkg::QUEUE_W;
	localparam int CFG_IDX_W   = plic_pkg::CFG_IDX_W;
	localparam int IN_TDATA_W  = plic_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = plic_pkg::OUT_TDATA_W;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ENABLE = plic_pkg::REG_SAMPLE_ENABLE;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_PS   = plic_pkg::REG_INTERVAL_PS;
	localparam logic [WORD_W-1:0]    INTERVAL_RST      = plic_pkg::INTERVAL_RST;
	localparam logic OP_RECORD = plic_pkg::OP_RECORD;
	localparam logic OP_FLUSH  = plic_pkg::OP_FLUSH;

	localparam int NLINKS      = plic_pkg::NUM_LINKS_DEF;
	localparam int SETTLE      = 200;   // longer than a full flush scan
	localparam int STALL_LIMIT = 4000;  // cycles without any transaction
	localparam int HOLD_AT     = 130;   // input count that starts the long sink hold-off
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_PRINTS  = 50;
	localparam logic [WORD_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic               op;
		logic [ID_W-1:0]    link;
		logic [WORD_W-1:0]  now;
		logic [BYTE_W-1:0]  nbytes;
		logic [QUEUE_W-1:0] depth;
	} link_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    link_id;
		logic [WORD_W-1:0]  bucket;
		logic [WORD_W-1:0]  nbytes;
		logic [QUEUE_W-1:0] max_depth;
		logic               last;
	} bucket_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	per_link_interval_load_counter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pending stimulus and predicted bucket reports
	link_item_t     stim_q[$];
	bucket_report_t bucket_reports_q[$];

	// Predictor copy of configuration and link table
	logic              sampling_on;
	logic [WORD_W-1:0] bucket_len;
	logic              seen_link[NLINKS];
	logic [WORD_W-1:0] open_bucket[NLINKS];
	logic [WORD_W-1:0] open_bytes[NLINKS];
	logic [QUEUE_W-1:0] open_max_depth[NLINKS];
	logic              flush_taken;

	int          error_count = 0;
	int          items_taken = 0;
	int          results_seen = 0;
	int          reg_writes = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        no_gaps = 1'b0;
	logic [WORD_W-1:0] time_cursor = '0;

	task automatic report_mismatch(string msg);
		if (error_count < MAX_PRINTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void report_bucket(int l);
		bucket_report_t r;
		if (open_bytes[l] == '0 && open_max_depth[l] == '0)
			return;
		r.link_id   = ID_W'(l);
		r.bucket    = open_bucket[l];
		r.nbytes    = open_bytes[l];
		r.max_depth = open_max_depth[l];
		r.last      = 1'b0;
		bucket_reports_q.push_back(r);
	endfunction

	// Advances the link table by one accepted item and queues the buckets it closes
	function automatic void advance_link_table(link_item_t it);
		int                before_cnt;
		int                l;
		logic [WORD_W-1:0] bkt;
		logic [WORD_W:0]   sum;
		before_cnt = bucket_reports_q.size();
		l = int'(it.link);
		if (!sampling_on)
			return;
		if (it.op == OP_RECORD) begin
			if (it.nbytes == '0 || bucket_len == '0)
				return;
			bkt = it.now / bucket_len;
			if (!seen_link[l]) begin
				open_bucket[l] = bkt;
				seen_link[l] = 1'b1;
			end else if (bkt != open_bucket[l]) begin
				report_bucket(l);
				open_bucket[l] = bkt;
				open_bytes[l] = '0;
				open_max_depth[l] = '0;
			end
			sum = {1'b0, open_bytes[l]} + it.nbytes;
			open_bytes[l] = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
			if (it.depth != '0 && it.depth > open_max_depth[l])
				open_max_depth[l] = it.depth;
		end else begin
			if (flush_taken)
				return;
			for (int i = 0; i < NLINKS; i++) begin
				if (seen_link[i]) begin
					report_bucket(i);
					open_bytes[i] = '0;
					open_max_depth[i] = '0;
				end
			end
			flush_taken = 1'b1;
		end
		if (bucket_reports_q.size() > before_cnt)
			bucket_reports_q[bucket_reports_q.size() - 1].last = 1'b1;
	endfunction

	function automatic link_item_t make_record(int l, logic [WORD_W-1:0] now,
			logic [BYTE_W-1:0] nb, logic [QUEUE_W-1:0] d);
		link_item_t it;
		it.op = OP_RECORD;
		it.link = ID_W'(l);
		it.now = now;
		it.nbytes = nb;
		it.depth = d;
		return it;
	endfunction

	function automatic link_item_t make_flush();
		link_item_t it;
		it = make_record($urandom_range(0, NLINKS - 1), {16'($urandom()), 32'($urandom())},
			16'($urandom()), $urandom());
		it.op = OP_FLUSH;
		return it;
	endfunction

	// Mostly a handful of busy links with time moving forward, some noise around it
	task automatic queue_random_items(int count, int unsigned step_max);
		link_item_t it;
		repeat (count) begin
			it.op = ($urandom_range(0, 99) < 3) ? OP_FLUSH : OP_RECORD;
			if ($urandom_range(0, 99) < 80)
				it.link = ID_W'($urandom_range(0, 7));
			else
				it.link = ID_W'($urandom());
			time_cursor = time_cursor + $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < 10)
				it.now = {16'($urandom()), 32'($urandom())};
			else
				it.now = time_cursor;
			it.nbytes = ($urandom_range(0, 99) < 5) ? '0 : BYTE_W'($urandom_range(1, 65535));
			it.depth = ($urandom_range(0, 99) < 30) ? '0 : $urandom();
			stim_q.push_back(it);
		end
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SAMPLE_ENABLE)
			sampling_on = val[0];
		else
			bucket_len = val;
		reg_writes++;
	endtask

	// Sender pause: nothing offered until every predicted bucket has come back
	task automatic settle_all();
		while (stim_q.size() != 0 || s_axis_tvalid || bucket_reports_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Driver
	always @(posedge clk) begin : drive_items
		link_item_t cur_item;
		link_item_t nxt;
		logic offer;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_link_table(cur_item);
				items_taken <= items_taken + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				offer = stim_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 19);
				if (offer) begin
					nxt = stim_q.pop_front();
					cur_item = nxt;
					s_axis_tdata <= {{(IN_TDATA_W - ID_W - WORD_W - BYTE_W - QUEUE_W){1'b0}},
						nxt.depth, nxt.nbytes, nxt.now, nxt.link};
					s_axis_tuser <= nxt.op;
				end
				s_axis_tvalid <= offer;
			end
		end
	end

	// Monitor
	always @(posedge clk) begin : watch_results
		bucket_report_t got;
		bucket_report_t want;
		logic rdy;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.link_id   = m_axis_tdata[ID_W-1:0];
				got.bucket    = m_axis_tdata[ID_W +: WORD_W];
				got.nbytes    = m_axis_tdata[ID_W + WORD_W +: WORD_W];
				got.max_depth = m_axis_tdata[ID_W + 2 * WORD_W +: QUEUE_W];
				got.last      = m_axis_tlast;
				results_seen <= results_seen + 1;
				if (bucket_reports_q.size() == 0) begin
					report_mismatch($sformatf("result %0d: unexpected report for link %0d",
						results_seen, got.link_id));
				end else begin
					want = bucket_reports_q.pop_front();
					if (got.link_id !== want.link_id)
						report_mismatch($sformatf("result %0d link_id: got %0d, expected %0d",
							results_seen, got.link_id, want.link_id));
					if (got.bucket !== want.bucket)
						report_mismatch($sformatf("result %0d bucket_number: got %0h, expected %0h",
							results_seen, got.bucket, want.bucket));
					if (got.nbytes !== want.nbytes)
						report_mismatch($sformatf("result %0d bucket_bytes: got %0h, expected %0h",
							results_seen, got.nbytes, want.nbytes));
					if (got.max_depth !== want.max_depth)
						report_mismatch($sformatf(
							"result %0d bucket_max_queue: got %0h, expected %0h",
							results_seen, got.max_depth, want.max_depth));
					if (got.last !== want.last)
						report_mismatch($sformatf("result %0d tlast: got %0b, expected %0b",
							results_seen, got.last, want.last));
				end
			end
			// one long hold-off while the sender keeps offering, so the block backs up
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rdy = 1'b0;
			end else if (!hold_done && items_taken >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				rdy = 1'b0;
			end else begin
				rdy = no_gaps || $urandom_range(0, 99) >= 19;
			end
			m_axis_tready <= rdy;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sampling_on = 1'b0;
		bucket_len = INTERVAL_RST;
		flush_taken = 1'b0;
		for (int i = 0; i < NLINKS; i++) begin
			seen_link[i] = 1'b0;
			open_bucket[i] = '0;
			open_bytes[i] = '0;
			open_max_depth[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// sampling off after reset: record and flush leave no trace
		stim_q.push_back(make_record(5, 48'd1000, 16'd100, 32'd7));
		stim_q.push_back(make_flush());
		settle_all();

		write_register(REG_SAMPLE_ENABLE, 48'd1);
		write_register(REG_INTERVAL_PS, 48'd1000);
		stim_q.push_back(make_record(0, 48'd0, 16'd1, 32'd0));
		stim_q.push_back(make_record(0, 48'd999, 16'hFFFF, 32'hFFFF_FFFF));
		stim_q.push_back(make_record(0, 48'd1000, 16'd10, 32'd0));
		stim_q.push_back(make_record(63, TIME_MAX, 16'hFFFF, 32'd0));
		stim_q.push_back(make_record(63, 48'd0, 16'd0, 32'd5));      // zero bytes
		stim_q.push_back(make_record(63, 48'd5, 16'd3, 32'd0));
		stim_q.push_back(make_record(63, 48'd2500, 16'd4, 32'd0));
		stim_q.push_back(make_record(7, 48'd100, 16'd1, 32'd9));
		stim_q.push_back(make_record(7, 48'd200, 16'd1, 32'd4));
		stim_q.push_back(make_record(9, 48'd0, 16'd5, 32'd0));
		stim_q.push_back(make_flush());
		stim_q.push_back(make_flush());                               // second flush is dead
		stim_q.push_back(make_record(9, 48'd5000, 16'd2, 32'd0));    // closes an empty bucket
		stim_q.push_back(make_record(9, 48'd6000, 16'd1, 32'd0));
		stim_q.push_back(make_record(0, 48'd1500, 16'd8, 32'd3));
		settle_all();

		write_register(REG_INTERVAL_PS, 48'd0);
		stim_q.push_back(make_record(0, 48'd9000, 16'd5, 32'd5));
		settle_all();
		write_register(REG_INTERVAL_PS, TIME_MAX);
		stim_q.push_back(make_record(1, 48'd0, 16'd1, 32'd1));
		stim_q.push_back(make_record(1, TIME_MAX, 16'd1, 32'd1));
		settle_all();
		write_register(REG_INTERVAL_PS, 48'd1);
		stim_q.push_back(make_record(2, 48'd7, 16'd1, 32'd0));
		stim_q.push_back(make_record(2, 48'd8, 16'd1, 32'd0));
		settle_all();

		// random traffic, first batch without any idle cycles
		write_register(REG_INTERVAL_PS, 48'd1000);
		time_cursor = '0;
		no_gaps <= 1'b1;
		queue_random_items(80, 400);
		settle_all();
		no_gaps <= 1'b0;

		write_register(REG_INTERVAL_PS, WORD_W'($urandom_range(2, 5000)));
		time_cursor = 48'h0000_8000_0000;
		queue_random_items(100, int'(bucket_len / 2));
		settle_all();

		write_register(REG_SAMPLE_ENABLE, 48'd0);
		queue_random_items(20, 500);
		settle_all();
		write_register(REG_SAMPLE_ENABLE, 48'd1);

		write_register(REG_INTERVAL_PS, 48'd1);
		time_cursor = 48'hFFFF_FF00_0000;
		queue_random_items(80, 2);
		settle_all();

		write_register(REG_INTERVAL_PS, 48'd1000);
		time_cursor = 48'd5_000_000;
		for (int i = 0; i < 60; i++) begin
			queue_random_items(1, 300);
			stim_q[stim_q.size() - 1].link = ID_W'($urandom());
		end
		settle_all();

		$display("Run covered %0d input transactions, %0d bucket reports, %0d register writes,",
			items_taken, results_seen, reg_writes);
		$display("with sampling on and off, intervals of zero, one, small and full range, and flush.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/plic_pkg.sv
hw/rtl/plic_ctrl.sv
hw/rtl/plic_datapath.sv
hw/rtl/per_link_interval_load_counter_top.sv
bench/per_link_interval_load_counter_top_tb.sv
